>>> src/nucleotide_range_minimum_core_macros.svh
// ----------------------------------------------------------------------------
// nucleotide_range_minimum_core_macros
// Assertion macros used by the checker file of the range minimum core.
// ----------------------------------------------------------------------------
`ifndef NUCLEOTIDE_RANGE_MINIMUM_CORE_MACROS_SVH
`define NUCLEOTIDE_RANGE_MINIMUM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrm assertion failed");

`endif

>>> src/nrm_pkg.sv
// ----------------------------------------------------------------------------
// nrm_pkg
// Types, constants and the letter-to-factor map of the range minimum core.
// ----------------------------------------------------------------------------
package nrm_pkg;

  localparam int POS_W    = 12;
  localparam int LETTER_W = 8;
  localparam int FACTOR_W = 3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [LETTER_W-1:0] CHAR_A = 8'h41;
  localparam logic [LETTER_W-1:0] CHAR_C = 8'h43;
  localparam logic [LETTER_W-1:0] CHAR_G = 8'h47;
  localparam logic [LETTER_W-1:0] CHAR_T = 8'h54;

  localparam logic [FACTOR_W-1:0] FACTOR_INVALID = 3'd0;
  localparam logic [FACTOR_W-1:0] FACTOR_A       = 3'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_C       = 3'd2;
  localparam logic [FACTOR_W-1:0] FACTOR_G       = 3'd3;
  localparam logic [FACTOR_W-1:0] FACTOR_T       = 3'd4;
  localparam logic [FACTOR_W-1:0] FACTOR_NONE    = 3'd7;

  typedef logic [FACTOR_W-1:0] factor_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;     // load transaction accepted
    logic q_start;   // query transaction accepted
    logic rd_en;     // read the entry at the scan pointer and advance
    logic acc_en;    // fold the returned entry into the running minimum
    logic out_load;  // move the result into the output register
  } nrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic q_empty;   // query range holds no position
    logic q_last;    // scan pointer sits on the last position
  } nrm_sts_t;

  function automatic factor_t letter_factor(input logic [LETTER_W-1:0] b);
    factor_t f;
    unique case (b)
      CHAR_A:  f = FACTOR_A;
      CHAR_C:  f = FACTOR_C;
      CHAR_G:  f = FACTOR_G;
      CHAR_T:  f = FACTOR_T;
      default: f = FACTOR_INVALID;
    endcase
    return f;
  endfunction

endpackage

>>> src/nucleotide_range_minimum_core.sv
// Load: one per cycle while no query occupies the core, written to the store at
// the accepting edge; no result. Query over n positions: n store reads in SCAN,
// DRAIN for the registered read data, then the result load in DONE, after which
// out_valid rises and the core is idle again; an empty query skips to DONE.
// A query waits in its last state while the previous result awaits out_ready.
// Reset (rst_n low, synchronous) clears controller and out_valid, not the store.
// ----------------------------------------------------------------------------
// nucleotide_range_minimum_core
// Range minimum of nucleotide impact factors over a loaded DNA sequence.
// ----------------------------------------------------------------------------
module nucleotide_range_minimum_core
  import nrm_pkg::*;
#(
  parameter int SEQ_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic [POS_W-1:0]    in_first_pos,
  input  logic [POS_W-1:0]    in_last_pos,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FACTOR_W-1:0] out_min_factor,
  output logic                out_empty_range
);

  nrm_cmd_t cmd;
  nrm_sts_t sts;

  nrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nrm_datapath #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_dp (
    .clk             (clk),
    .in_letter       (in_letter),
    .in_first_pos    (in_first_pos),
    .in_last_pos     (in_last_pos),
    .cmd             (cmd),
    .sts             (sts),
    .out_min_factor  (out_min_factor),
    .out_empty_range (out_empty_range)
  );

endmodule

>>> src/nrm_ram.sv
// ----------------------------------------------------------------------------
// nrm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nrm_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/nrm_ctrl.sv
// ----------------------------------------------------------------------------
// nrm_ctrl
// Controller: handshakes, scan sequencing and output register valid.
// ----------------------------------------------------------------------------
module nrm_ctrl
  import nrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_func,
  output logic     out_valid,
  input  logic     out_ready,
  input  nrm_sts_t sts,
  output nrm_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       rd_pend_r, rd_pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.wr_en    = in_acc && (in_func == FUNC_LOAD);
    cmd.q_start  = in_acc && (in_func == FUNC_QUERY);
    cmd.acc_en   = rd_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.q_start) begin
          state_nxt = sts.q_empty ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.q_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_pend_nxt   = cmd.rd_en;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/nrm_datapath.sv
// ----------------------------------------------------------------------------
// nrm_datapath
// Sequence store, scan pointer, running minimum and result register.
// ----------------------------------------------------------------------------
module nrm_datapath
  import nrm_pkg::*;
#(
  parameter int SEQ_DEPTH = 4096
) (
  input  logic                clk,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic [POS_W-1:0]    in_first_pos,
  input  logic [POS_W-1:0]    in_last_pos,
  input  nrm_cmd_t            cmd,
  output nrm_sts_t            sts,
  output logic [FACTOR_W-1:0] out_min_factor,
  output logic                out_empty_range
);

  localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam logic [31:0] DEPTH_W = 32'(SEQ_DEPTH);
  localparam logic [31:0] LAST_W  = 32'(SEQ_DEPTH - 1);

  logic [31:0]   first_w;
  logic [31:0]   last_w;
  logic [31:0]   last_clip_w;
  logic          ld_in_range;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] last_r, last_nxt;
  factor_t       best_r, best_nxt;
  factor_t       rd_factor;
  factor_t       min_r, min_nxt;
  logic          empty_r, empty_nxt;

  assign first_w     = 32'(in_first_pos);
  assign last_w      = 32'(in_last_pos);
  assign last_clip_w = (last_w > LAST_W) ? LAST_W : last_w;
  assign ld_in_range = (first_w < DEPTH_W);

  // Also covers a first position beyond the store, since the clipped last is inside it.
  assign sts.q_empty = (first_w > last_clip_w);
  assign sts.q_last  = (cur_r == last_r);

  nrm_ram #(
    .WIDTH (FACTOR_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en && ld_in_range),
    .waddr (AW'(first_w)),
    .wdata (letter_factor(in_letter)),
    .re    (cmd.rd_en),
    .raddr (cur_r),
    .rdata (rd_factor)
  );

  always_comb begin
    cur_nxt   = cur_r;
    last_nxt  = last_r;
    best_nxt  = best_r;
    min_nxt   = min_r;
    empty_nxt = empty_r;
    if (cmd.q_start) begin
      cur_nxt  = AW'(first_w);
      last_nxt = AW'(last_clip_w);
      best_nxt = FACTOR_NONE;
    end
    if (cmd.rd_en) begin
      cur_nxt = cur_r + AW'(1);
    end
    // Skip invalid entries.
    if (cmd.acc_en && (rd_factor != FACTOR_INVALID) && (rd_factor < best_r)) begin
      best_nxt = rd_factor;
    end
    if (cmd.out_load) begin
      empty_nxt = (best_r == FACTOR_NONE);
      min_nxt   = (best_r == FACTOR_NONE) ? FACTOR_INVALID : best_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    last_r  <= last_nxt;
    best_r  <= best_nxt;
    min_r   <= min_nxt;
    empty_r <= empty_nxt;
  end

  assign out_min_factor  = min_r;
  assign out_empty_range = empty_r;

endmodule

>>> src/nrm_checker.sv
// ----------------------------------------------------------------------------
// nrm_checker
// Port-level checks of the range minimum core, bound to the top level.
// ----------------------------------------------------------------------------
`include "nucleotide_range_minimum_core_macros.svh"

module nrm_checker
  import nrm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_func,
  input logic                out_valid,
  input logic                out_ready,
  input logic [FACTOR_W-1:0] out_min_factor,
  input logic                out_empty_range
);

  // Hold a pending result until the transaction completes.
  `NRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Empty flag and zero factor go together.
  `NRM_ASSERT_NOW(a_empty_match, clk, rst_n, out_valid,
                  out_empty_range == (out_min_factor == FACTOR_INVALID))

  `NRM_ASSERT_NOW(a_factor_range, clk, rst_n, out_valid, out_min_factor <= FACTOR_T)

  // A query occupies the block: no new transaction in the next cycle.
  `NRM_ASSERT_NEXT(a_query_busy, clk, rst_n,
                   in_valid && in_ready && (in_func == FUNC_QUERY), !in_ready)

  // A load never produces a result.
  `NRM_ASSERT_NEXT(a_load_silent, clk, rst_n,
                   in_valid && in_ready && (in_func == FUNC_LOAD) && !out_valid,
                   !out_valid)

endmodule

bind nucleotide_range_minimum_core nrm_checker u_nrm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_min_factor  (out_min_factor),
  .out_empty_range (out_empty_range)
);

>>> verif/tb_nucleotide_range_minimum_core.sv
// ----------------------------------------------------------------------------
// tb_nucleotide_range_minimum_core
// Loads DNA letters into the core's sequence store and issues range minimum
// queries over written positions only. A scoreboard keeps its own copy of the
// store, forecasts each query result and checks it against the output.
// ----------------------------------------------------------------------------
module tb_nucleotide_range_minimum_core;
  import nrm_pkg::*;

  localparam int SEQ_DEPTH  = 4096;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 8;

  typedef struct {
    logic                func;
    logic [LETTER_W-1:0] letter;
    logic [POS_W-1:0]    first_pos;
    logic [POS_W-1:0]    last_pos;
  } seq_op_t;

  typedef struct {
    factor_t min_factor;
    logic    empty_range;
  } range_min_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = FUNC_LOAD;
  logic [LETTER_W-1:0] in_letter = '0;
  logic [POS_W-1:0]    in_first_pos = '0;
  logic [POS_W-1:0]    in_last_pos = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [FACTOR_W-1:0] out_min_factor;
  logic                out_empty_range;

  seq_op_t    seq_ops_q[$];
  range_min_t min_results_q[$];
  factor_t    store_copy [SEQ_DEPTH];
  bit         written [SEQ_DEPTH];
  int         send_idle_pct = 10;
  int         recv_idle_pct = 71;
  int         ops_queued = 0;
  int         ops_taken = 0;
  int         errors = 0;
  int         quiet_cycles = 0;

  nucleotide_range_minimum_core #(
    .SEQ_DEPTH(SEQ_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_letter      (in_letter),
    .in_first_pos   (in_first_pos),
    .in_last_pos    (in_last_pos),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_factor (out_min_factor),
    .out_empty_range(out_empty_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic factor_t nucleotide_weight(logic [LETTER_W-1:0] b);
    if (b == CHAR_A) return FACTOR_A;
    else if (b == CHAR_C) return FACTOR_C;
    else if (b == CHAR_G) return FACTOR_G;
    else if (b == CHAR_T) return FACTOR_T;
    return FACTOR_INVALID;
  endfunction

  function automatic range_min_t scan_min_factor(int first, int last);
    range_min_t r;
    factor_t    best;
    best = FACTOR_NONE;
    if (last >= SEQ_DEPTH) last = SEQ_DEPTH - 1;
    for (int i = first; i <= last; i++) begin
      if (store_copy[i] != FACTOR_INVALID && store_copy[i] < best) best = store_copy[i];
    end
    if (best == FACTOR_NONE) begin
      r.min_factor  = FACTOR_INVALID;
      r.empty_range = 1'b1;
    end else begin
      r.min_factor  = best;
      r.empty_range = 1'b0;
    end
    return r;
  endfunction

  // Driver: hold the payload while stalled, fold accepted loads into the copy and forecast accepted queries.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) begin
        ops_taken++;
        if (in_func == FUNC_LOAD) begin
          if (in_first_pos < SEQ_DEPTH) store_copy[in_first_pos] = nucleotide_weight(in_letter);
        end else begin
          min_results_q.insert(min_results_q.size(),
                               scan_min_factor(in_first_pos, in_last_pos));
        end
      end
      if (seq_ops_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        seq_op_t op;
        op = seq_ops_q.pop_front();
        in_valid     <= 1'b1;
        in_func      <= op.func;
        in_letter    <= op.letter;
        in_first_pos <= op.first_pos;
        in_last_pos  <= op.last_pos;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest forecast.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (min_results_q.size() == 0) begin
          $display("%0t: unexpected result min_factor %0d empty_range %0d",
                   $time, out_min_factor, out_empty_range);
          errors++;
        end else begin
          range_min_t exp_r;
          exp_r = min_results_q.pop_front();
          if (out_min_factor !== exp_r.min_factor) begin
            $display("%0t: min_factor expected %0d actual %0d",
                     $time, exp_r.min_factor, out_min_factor);
            errors++;
          end
          if (out_empty_range !== exp_r.empty_range) begin
            $display("%0t: empty_range expected %0d actual %0d",
                     $time, exp_r.empty_range, out_empty_range);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_op(logic func, int letter, int first, int last);
    seq_op_t op;
    op.func      = func;
    op.letter    = letter[LETTER_W-1:0];
    op.first_pos = first[POS_W-1:0];
    op.last_pos  = last[POS_W-1:0];
    if (func == FUNC_LOAD && first < SEQ_DEPTH) written[first] = 1'b1;
    seq_ops_q.insert(seq_ops_q.size(), op);
    ops_queued++;
  endtask

  task automatic add_empty_query();
    int first;
    first = $urandom_range(SEQ_DEPTH - 1, 1);
    push_op(FUNC_QUERY, $urandom_range(255), first, $urandom_range(first - 1));
  endtask

  // Pick a written position and grow the range only over written entries; else issue an empty query.
  task automatic add_range_query();
    int p, lo, hi, span;
    p = -1;
    for (int tries = 0; tries < 40 && p < 0; tries++) begin
      lo = ($urandom_range(9) < 6) ? $urandom_range(31) : $urandom_range(4095, 4064);
      if (written[lo]) p = lo;
    end
    if (p < 0) begin
      add_empty_query();
    end else begin
      span = ($urandom_range(9) == 0) ? 64 : $urandom_range(12);
      lo = p;
      hi = p;
      while (hi < SEQ_DEPTH - 1 && hi - lo < span && written[hi + 1]) hi++;
      while (lo > 0 && hi - lo < span && $urandom_range(1) == 1 && written[lo - 1]) lo--;
      push_op(FUNC_QUERY, $urandom_range(255), lo, hi);
    end
  endtask

  task automatic add_random_load();
    int pos, letter;
    case ($urandom_range(9))
      0:       pos = $urandom_range(SEQ_DEPTH - 1);
      1, 2, 3: pos = $urandom_range(4095, 4064);
      default: pos = $urandom_range(31);
    endcase
    case ($urandom_range(19))
      0, 1, 2: letter = $urandom_range(255);
      3, 4, 5, 6: letter = CHAR_A;
      7, 8, 9, 10: letter = CHAR_C;
      11, 12, 13, 14: letter = CHAR_G;
      default: letter = CHAR_T;
    endcase
    push_op(FUNC_LOAD, letter, pos, $urandom_range(SEQ_DEPTH - 1));
  endtask

  task automatic add_random_ops(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) add_random_load();
      else if (pick < 92) add_range_query();
      else add_empty_query();
    end
  endtask

  task automatic wait_drained(bit all_results);
    while (ops_taken != ops_queued || (all_results && min_results_q.size() != 0))
      @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Letters of every kind, low and high ends of the store.
    push_op(FUNC_LOAD, CHAR_A, 0, 0);
    push_op(FUNC_LOAD, CHAR_C, 1, 4095);
    push_op(FUNC_LOAD, CHAR_G, 2, 0);
    push_op(FUNC_LOAD, CHAR_T, 3, 0);
    push_op(FUNC_LOAD, 8'hFF, 4, 0);
    push_op(FUNC_LOAD, 8'h00, 5, 0);
    push_op(FUNC_LOAD, 8'h61, 6, 0);
    push_op(FUNC_LOAD, CHAR_T, 4095, 4095);
    push_op(FUNC_LOAD, CHAR_G, 4094, 0);
    push_op(FUNC_LOAD, 8'h80, 4093, 0);
    push_op(FUNC_QUERY, 8'h00, 0, 3);
    push_op(FUNC_QUERY, 8'h00, 1, 3);
    push_op(FUNC_QUERY, 8'h00, 2, 2);
    push_op(FUNC_QUERY, 8'h00, 3, 6);
    // range made only of invalid entries
    push_op(FUNC_QUERY, 8'h00, 4, 6);
    push_op(FUNC_QUERY, 8'hFF, 4095, 4095);
    push_op(FUNC_QUERY, 8'h00, 4093, 4095);
    push_op(FUNC_QUERY, 8'h00, 4093, 4093);
    // first beyond last
    push_op(FUNC_QUERY, 8'hFF, 4095, 0);
    push_op(FUNC_QUERY, 8'h00, 5, 4);
    push_op(FUNC_QUERY, 8'h00, 0, 0);
    push_op(FUNC_QUERY, 8'h00, 0, 6);
    // overwrite an entry
    push_op(FUNC_LOAD, CHAR_C, 0, 4095);
    push_op(FUNC_QUERY, 8'h00, 0, 1);
    wait_drained(1'b1);

    add_random_ops(38);
    wait_drained(1'b0);
    send_idle_pct = 71;
    recv_idle_pct = 10;
    add_random_ops(20);
    // hold off the sender until every result is back
    wait_drained(1'b1);
    add_random_ops(20);
    wait_drained(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_ops(38);
    wait_drained(1'b1);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> nucleotide_range_minimum_core.f
+incdir+src
src/nrm_pkg.sv
src/nrm_ram.sv
src/nrm_ctrl.sv
src/nrm_datapath.sv
src/nucleotide_range_minimum_core.sv
src/nrm_checker.sv
verif/tb_nucleotide_range_minimum_core.sv
